>>> sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: sizes, operation
// and status codes, cell commands and the link between neighboring cells.
// ----------------------------------------------------------------------------
package deq_pkg;

   // queue geometry
   localparam int DEPTH  = 32;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   // operation codes carried by req_mode
   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_LIST       = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // command broadcast to every cell in the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_SHIFT_IN,
      CMD_SHIFT_OUT,
      CMD_PUSH_BACK,
      CMD_POP_BACK,
      CMD_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      word_type     value;
   } cell_ctl_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic     valid;
      word_type data;
   } link_type;

   // control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

endpackage

>>> sv/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain. Holds a word and an occupied flag; shifts
// toward either neighbor, takes a push at the back, drops a pop at the back
// and rotates toward the front during a list.
// ----------------------------------------------------------------------------
module deq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_pkg::cell_ctl_type ctl_i,
   input  deq_pkg::word_type     head_i,
   input  deq_pkg::link_type     left_i,
   input  deq_pkg::link_type     right_i,
   output deq_pkg::link_type     link_o
);

   logic              valid_ff, valid_in;
   deq_pkg::word_type data_ff, data_in;

   // next slot contents per chain command
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctl_i.cmd)
         deq_pkg::CMD_SHIFT_IN: begin
            valid_in = left_i.valid;
            data_in  = left_i.data;
         end
         deq_pkg::CMD_SHIFT_OUT: begin
            valid_in = right_i.valid;
            data_in  = right_i.data;
         end
         deq_pkg::CMD_PUSH_BACK: begin
            // first free slot after the occupied run takes the word
            if (left_i.valid && !valid_ff) begin
               valid_in = 1'b1;
               data_in  = ctl_i.value;
            end
         end
         deq_pkg::CMD_POP_BACK: begin
            if (valid_ff && !right_i.valid) begin
               valid_in = 1'b0;
            end
         end
         deq_pkg::CMD_ROTATE: begin
            // last occupied slot wraps the front word around
            if (valid_ff) begin
               data_in = right_i.valid ? right_i.data : head_i;
            end
         end
         default: begin
            valid_in = valid_ff;
            data_in  = data_ff;
         end
      endcase
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stored word
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link_o.valid = valid_ff;
   assign link_o.data  = data_ff;

endmodule

>>> sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for the queue: decodes each operation, tracks occupancy, drives
// the chain command and holds the result register toward the output.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  deq_pkg::word_type     req_value,
   input  deq_pkg::word_type     head_i,
   output deq_pkg::cell_ctl_type ctl_o,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output deq_pkg::word_type     rsp_item,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last
);

   deq_pkg::state_type  state_ff, state_in;
   deq_pkg::cnt_type    cnt_ff, cnt_in;
   deq_pkg::cnt_type    list_k_ff, list_k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   deq_pkg::word_type   item_ff, item_in;
   deq_pkg::status_type status_ff, status_in;
   logic                last_ff, last_in;
   logic                load;
   logic                accept;
   logic                out_free;
   logic                full;
   logic                empty;
   logic                list_end;

   // handshake and queue flags
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != deq_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (cnt_ff == deq_pkg::CNT_W'(deq_pkg::DEPTH));
   assign empty     = (cnt_ff == '0);
   assign list_end  = (deq_pkg::CNT_W'(list_k_ff + 1'b1) == cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept && (req_mode == deq_pkg::MODE_LIST) && !empty &&
                (cnt_ff != deq_pkg::CNT_W'(1))) begin
               state_in = deq_pkg::ST_LIST;
            end
         end
         deq_pkg::ST_LIST: begin
            if (out_free && list_end) begin
               state_in = deq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   // chain command, occupancy and result
   always_comb begin
      ctl_o.cmd   = deq_pkg::CMD_HOLD;
      ctl_o.value = req_value;
      cnt_in      = cnt_ff;
      list_k_in   = list_k_ff;
      load        = 1'b0;
      item_in     = '0;
      status_in   = deq_pkg::STAT_OK;
      last_in     = 1'b1;
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  deq_pkg::MODE_PUSH_FRONT,
                  deq_pkg::MODE_PUSH_BACK: begin
                     load = 1'b1;
                     if (full) begin
                        status_in = deq_pkg::STAT_FULL;
                     end else begin
                        ctl_o.cmd = (req_mode == deq_pkg::MODE_PUSH_FRONT) ?
                                    deq_pkg::CMD_SHIFT_IN : deq_pkg::CMD_PUSH_BACK;
                        cnt_in    = deq_pkg::CNT_W'(cnt_ff + 1'b1);
                     end
                  end
                  deq_pkg::MODE_POP_FRONT,
                  deq_pkg::MODE_POP_BACK: begin
                     load = 1'b1;
                     if (empty) begin
                        status_in = deq_pkg::STAT_EMPTY;
                     end else begin
                        ctl_o.cmd = (req_mode == deq_pkg::MODE_POP_FRONT) ?
                                    deq_pkg::CMD_SHIFT_OUT : deq_pkg::CMD_POP_BACK;
                        cnt_in    = deq_pkg::CNT_W'(cnt_ff - 1'b1);
                     end
                  end
                  deq_pkg::MODE_LIST: begin
                     load = 1'b1;
                     if (empty) begin
                        status_in = deq_pkg::STAT_EMPTY;
                     end else begin
                        // first entry goes out now, the chain rotates by one
                        ctl_o.cmd = deq_pkg::CMD_ROTATE;
                        item_in   = head_i;
                        last_in   = (cnt_ff == deq_pkg::CNT_W'(1));
                        list_k_in = deq_pkg::CNT_W'(1);
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         deq_pkg::ST_LIST: begin
            if (out_free) begin
               load      = 1'b1;
               ctl_o.cmd = deq_pkg::CMD_ROTATE;
               item_in   = head_i;
               last_in   = list_end;
               list_k_in = deq_pkg::CNT_W'(list_k_ff + 1'b1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_stall && rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::ST_IDLE;
         cnt_ff       <= '0;
         list_k_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         list_k_ff    <= list_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff   <= item_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = item_ff;
   assign rsp_status = status_ff;
   assign rsp_last   = last_ff;

endmodule

>>> sv/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall) carries one operation per transfer:
//   push front, push back, pop front, pop back or list all. Undefined modes
//   are taken and ignored.
//   rsp channel (rsp_valid/rsp_stall) returns one result per push or pop
//   (status ok, empty or full) and, for a list, one result per entry from
//   front to back with rsp_last on the final one; an empty list gives one
//   empty status.
//   A result is registered and shows in the cycle after its request transfer.
//   Push and pop requests can follow back to back while results are not
//   stalled. A list of N entries returns one entry per cycle while results
//   are not stalled, with req_stall high until its last entry is loaded,
//   paced by the rotation of the cell chain toward the front.
//   A stalled result holds in the output register; a new request is taken
//   in the cycle the waiting result leaves.
//   Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_mode,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_item,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   deq_pkg::cell_ctl_type ctl;
   deq_pkg::link_type     links [deq_pkg::DEPTH];
   deq_pkg::link_type     front_edge;
   deq_pkg::link_type     back_edge;

   // chain boundaries: the front always looks occupied and feeds the push word
   assign front_edge.valid = 1'b1;
   assign front_edge.data  = req_value;
   assign back_edge.valid  = 1'b0;
   assign back_edge.data   = '0;

   // sequencer and result register
   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .head_i     (links[0].data),
      .ctl_o      (ctl),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   // row of slots, front at index zero
   for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
      deq_pkg::link_type left_link;
      deq_pkg::link_type right_link;

      if (i == 0) begin : g_first
         assign left_link = front_edge;
      end else begin : g_mid_l
         assign left_link = links[i-1];
      end

      if (i == deq_pkg::DEPTH - 1) begin : g_last
         assign right_link = back_edge;
      end else begin : g_mid_r
         assign right_link = links[i+1];
      end

      deq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl_i   (ctl),
         .head_i  (links[0].data),
         .left_i  (left_link),
         .right_i (right_link),
         .link_o  (links[i])
      );
   end

endmodule

>>> sv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [2:0]         req_mode,
   input logic signed [31:0] req_value,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_item,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item) &&
                                 $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result changed");

   // an error status is a single result with no word
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != deq_pkg::STAT_OK) |-> rsp_last && (rsp_item == '0))
      else $error("error result not single or not zero");

   // status code is one of the defined ones
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == deq_pkg::STAT_OK) ||
                    (rsp_status == deq_pkg::STAT_EMPTY) ||
                    (rsp_status == deq_pkg::STAT_FULL))
      else $error("undefined status code");

   // no request transfer while a list is still going out
   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken in the middle of a list");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_mode   (req_mode),
   .req_value  (req_value),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_item   (rsp_item),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

>>> verif/double_ended_queue_top_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_test
// Self-checking bench for the double-ended queue. A shadow ring store with a
// front index and a count predicts the result of every request transfer;
// results are checked in order, field by field. Directed tests cover the
// empty and full boundaries, extreme words and undefined modes; a random
// phase drives push-heavy and pop-heavy stretches with random back pressure.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;

   // undefined operation codes, taken and ignored by the block
   localparam logic [2:0] UNDEF_MODES [3] = '{3'd5, 3'd6, 3'd7};

   localparam deq_pkg::word_type WORD_MIN = 32'sh8000_0000;
   localparam deq_pkg::word_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam deq_pkg::word_type WORD_ODD = 32'sh5555_5555;
   localparam deq_pkg::word_type WORD_EVN = 32'shAAAA_AAAA;

   typedef struct {
      deq_pkg::word_type   item;
      deq_pkg::status_type status;
      logic                last;
   } deq_result_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_mode  = deq_pkg::MODE_LIST;
   logic signed [31:0] req_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_item;
   logic [1:0]        rsp_status;
   logic              rsp_last;

   // shadow copy of the queue contents
   deq_pkg::word_type shadow_slots [deq_pkg::DEPTH];
   int                shadow_front = 0;
   int                shadow_count = 0;

   deq_result_type rsp_expected [$];
   int             fail_count    = 0;
   bit             sender_idle   = 1'b1;
   bit             receiver_idle = 1'b1;

   double_ended_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_result(input deq_pkg::word_type item,
                                      input deq_pkg::status_type status,
                                      input logic last);
      deq_result_type r;
      r.item   = item;
      r.status = status;
      r.last   = last;
      rsp_expected.push_back(r);
   endfunction

   // shadow queue update and expected results for one accepted request
   function automatic void deque_apply(input logic [2:0] mode,
                                       input deq_pkg::word_type value);
      case (mode)
         deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
            if (shadow_count >= deq_pkg::DEPTH) begin
               add_result('0, deq_pkg::STAT_FULL, 1'b1);
            end else begin
               if (mode == deq_pkg::MODE_PUSH_FRONT) begin
                  shadow_front = (shadow_front + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                  shadow_slots[shadow_front] = value;
               end else begin
                  shadow_slots[(shadow_front + shadow_count) % deq_pkg::DEPTH] = value;
               end
               shadow_count++;
               add_result('0, deq_pkg::STAT_OK, 1'b1);
            end
         end
         deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
            if (shadow_count == 0) begin
               add_result('0, deq_pkg::STAT_EMPTY, 1'b1);
            end else begin
               if (mode == deq_pkg::MODE_POP_FRONT) begin
                  shadow_front = (shadow_front + 1) % deq_pkg::DEPTH;
               end
               shadow_count--;
               add_result('0, deq_pkg::STAT_OK, 1'b1);
            end
         end
         deq_pkg::MODE_LIST: begin
            if (shadow_count == 0) begin
               add_result('0, deq_pkg::STAT_EMPTY, 1'b1);
            end else begin
               for (int k = 0; k < shadow_count; k++) begin
                  add_result(shadow_slots[(shadow_front + k) % deq_pkg::DEPTH],
                             deq_pkg::STAT_OK, k + 1 == shadow_count);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic deq_pkg::word_type random_word();
      case ($urandom_range(0, 7))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         default: return deq_pkg::word_type'($urandom);
      endcase
   endfunction

   // one request transfer, preceded by a random gap
   task automatic drive_op(input logic [2:0] mode, input deq_pkg::word_type value);
      int gap;
      gap = sender_idle ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      deque_apply(mode, value);
   endtask

   // hold off new requests until every result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (rsp_expected.size() != 0);
   endtask

   // result checker
   always @(posedge clock) begin
      deq_result_type exp_r;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected result item=%0d status=%0d last=%0b",
                     $time, rsp_item, rsp_status, rsp_last);
            fail_count++;
         end else begin
            exp_r = rsp_expected.pop_front();
            if (rsp_item !== exp_r.item || rsp_status !== exp_r.status ||
                rsp_last !== exp_r.last) begin
               $display({"%0t: mismatch expected item=%0d status=%0d last=%0b,",
                         " got item=%0d status=%0d last=%0b"},
                        $time, exp_r.item, exp_r.status, exp_r.last,
                        rsp_item, rsp_status, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // result side back pressure, drawn per transfer
   initial begin
      int hold;
      wait (!reset);
      forever begin
         hold = receiver_idle ? $urandom_range(0, 19) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // pops, lists and undefined modes on an empty queue
   task automatic test_empty_queue();
      drive_op(deq_pkg::MODE_POP_FRONT, random_word());
      drive_op(deq_pkg::MODE_POP_BACK, random_word());
      drive_op(deq_pkg::MODE_LIST, random_word());
      foreach (UNDEF_MODES[i]) drive_op(UNDEF_MODES[i], random_word());
      drive_op(deq_pkg::MODE_LIST, '0);
   endtask

   // extreme words at both ends, popping the final entry, reuse after empty
   task automatic test_extreme_words();
      drive_op(deq_pkg::MODE_PUSH_FRONT, WORD_MAX);
      drive_op(deq_pkg::MODE_PUSH_BACK, WORD_MIN);
      drive_op(deq_pkg::MODE_PUSH_FRONT, '0);
      drive_op(deq_pkg::MODE_PUSH_BACK, '1);
      drive_op(deq_pkg::MODE_PUSH_FRONT, WORD_ODD);
      drive_op(deq_pkg::MODE_PUSH_BACK, WORD_EVN);
      drive_op(deq_pkg::MODE_LIST, '0);
      drive_op(deq_pkg::MODE_POP_FRONT, WORD_MAX);
      drive_op(deq_pkg::MODE_POP_BACK, WORD_MIN);
      drive_op(UNDEF_MODES[1], WORD_ODD);
      drive_op(deq_pkg::MODE_LIST, '1);
      drive_op(deq_pkg::MODE_POP_FRONT, '0);
      drive_op(deq_pkg::MODE_POP_BACK, '0);
      drive_op(deq_pkg::MODE_POP_FRONT, '0);
      drive_op(deq_pkg::MODE_POP_BACK, '0);
      drive_op(deq_pkg::MODE_LIST, '0);
      drive_op(deq_pkg::MODE_PUSH_BACK, WORD_EVN);
      drive_op(deq_pkg::MODE_LIST, '0);
      drive_op(deq_pkg::MODE_POP_BACK, '0);
   endtask

   // fill to capacity, pushes against a full queue, full list, drain, pop when empty
   task automatic test_full_queue();
      repeat (deq_pkg::DEPTH) begin
         drive_op($urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT,
                  random_word());
      end
      drive_op(deq_pkg::MODE_PUSH_FRONT, random_word());
      drive_op(deq_pkg::MODE_PUSH_BACK, random_word());
      drive_op(deq_pkg::MODE_LIST, '0);
      repeat (deq_pkg::DEPTH) begin
         drive_op($urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT,
                  random_word());
      end
      drive_op(deq_pkg::MODE_POP_FRONT, random_word());
   endtask

   // random traffic in stretches that lean toward filling or draining
   task automatic test_random_traffic(input int n_items);
      int done;
      int phase_left;
      int push_pct;
      int pick;
      done       = 0;
      phase_left = 0;
      push_pct   = 50;
      while (done < n_items) begin
         if (phase_left == 0) begin
            if ($urandom_range(0, 3) == 0) wait_drained();
            phase_left    = $urandom_range(20, 60);
            push_pct      = $urandom_range(15, 85);
            sender_idle   = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            drive_op(UNDEF_MODES[$urandom_range(0, 2)], random_word());
         end else begin
            if (pick < 13) begin
               drive_op(deq_pkg::MODE_LIST, random_word());
            end else if ($urandom_range(0, 99) < push_pct) begin
               drive_op($urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK :
                                               deq_pkg::MODE_PUSH_FRONT,
                        random_word());
            end else begin
               drive_op($urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK :
                                               deq_pkg::MODE_POP_FRONT,
                        random_word());
            end
            done++;
            phase_left--;
         end
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extreme_words();
      wait_drained();
      test_full_queue();
      test_random_traffic(365);
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0) begin
         $display("double_ended_queue_top_test: PASS");
      end else begin
         $display("double_ended_queue_top_test: FAIL");
      end
      $finish;
   end

   // run time limit
   initial begin
      #20000000;
      $display("double_ended_queue_top_test: FAIL");
      $finish;
   end

endmodule
